### rtl/core/sas_pkg.sv
// shared types, constants and compare helper for the sorted array store
`default_nettype none

package sas_pkg;

   localparam int unsigned DEPTH  = 1024;
   localparam int unsigned ELEM_W = 32;
   localparam int unsigned IDX_W  = $clog2(DEPTH);
   localparam int unsigned CNT_W  = IDX_W + 1;
   localparam int unsigned ACT_W  = 3;
   localparam int unsigned STAT_W = 2;

   typedef enum logic [ACT_W-1:0] {
      ACT_PUSH  = 3'd0,
      ACT_POP   = 3'd1,
      ACT_READ  = 3'd2,
      ACT_SWAP  = 3'd3,
      ACT_LOWER = 3'd4,
      ACT_UPPER = 3'd5,
      ACT_EXACT = 3'd6
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK   = 2'd0,
      STAT_ERR  = 2'd1,
      STAT_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MEM,
      ST_PROBE,
      ST_STEP,
      ST_CHECK,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD,
      OP_PUSH,
      OP_FULL,
      OP_FAIL,
      OP_RD_LAST,
      OP_RD_INDEX,
      OP_TAKE,
      OP_SRCH_INIT,
      OP_RD_MID,
      OP_STEP,
      OP_RD_FIRST,
      OP_POS_FIRST,
      OP_POS_CHECK
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      action_type act;
      logic       empty;
      logic       full;
      logic       idx_oob;
      logic       len_zero;
      logic       first_valid;
   } dp_stat_type;

   // a below b, unsigned or two's complement
   function automatic logic less_than(input logic [ELEM_W-1:0] a,
                                      input logic [ELEM_W-1:0] b,
                                      input logic              signed_mode);
      logic [ELEM_W-1:0] flip;
      flip = {signed_mode, {(ELEM_W-1){1'b0}}};
      return (a ^ flip) < (b ^ flip);
   endfunction

endpackage

`default_nettype wire

### rtl/core/sorted_array_store_with_search.sv
// top level: sorted array store with push, pop, read, swap remove and binary search
`default_nettype none

// A 1024-entry store of 32-bit elements with a fill count, one item at a time.
// Every item gives one result carrying status, data, position and the count after
// the item. Push, and any refused item, passes through the exec and done states;
// pop, read and swap remove also pass the mem state. A search runs a probe and a
// step state per probe against the entry memory with registered read data, up to
// ceil(log2(count+1)) probes, plus a check state for an exact search that lands
// inside the store. The result sits in an output register, so the next item is
// accepted while it waits. Searches assume the stored entries are sorted under
// the compare set by csr_key_signed (0 unsigned, 1 two's complement); csr writes
// are taken at any time and are meant for when the block is idle. Entries are
// never cleared at reset and only positions below the count are ever read.

module sorted_array_store_with_search (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // item input
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [sas_pkg::ACT_W-1:0]     req_action,
   input  wire logic [sas_pkg::IDX_W-1:0]     req_index,
   input  wire logic [sas_pkg::ELEM_W-1:0]    req_value,
   // result output
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [sas_pkg::STAT_W-1:0]         rsp_status,
   output logic [sas_pkg::ELEM_W-1:0]         rsp_data,
   output logic [sas_pkg::CNT_W-1:0]          rsp_position,
   output logic [sas_pkg::CNT_W-1:0]          rsp_count,
   // key compare mode register
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic                          csr_key_signed
);

   sas_pkg::ctrl_cmd_type cmd;
   sas_pkg::dp_stat_type  stat;

   // the register write always completes
   assign csr_ready = 1'b1;

   // state machine: accept, dispatch on action, probe loop, result handoff
   sas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // memory, count, search window, result registers
   sas_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_action     (req_action),
      .req_index      (req_index),
      .req_value      (req_value),
      .csr_we         (csr_valid & csr_ready),
      .csr_key_signed (csr_key_signed),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_status     (rsp_status),
      .rsp_data       (rsp_data),
      .rsp_position   (rsp_position),
      .rsp_count      (rsp_count)
   );

`ifndef SYNTHESIS
   // count can never pass the depth
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count <= sas_pkg::CNT_W'(sas_pkg::DEPTH))
      else $error("result count above depth");

   // a refused push only happens on a full store
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == sas_pkg::STAT_FULL)
      |-> rsp_count == sas_pkg::CNT_W'(sas_pkg::DEPTH))
      else $error("full status with room left");

   // a search position never lies beyond the count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_position <= rsp_count)
      else $error("position beyond count");

   // a new item is only taken once the previous result is loaded
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("two items in flight");
`endif

endmodule

`default_nettype wire

### rtl/core/sas_dp.sv
// datapath: entry memory, fill count, search window and result registers
`default_nettype none

module sas_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [sas_pkg::ACT_W-1:0]     req_action,
   input  wire logic [sas_pkg::IDX_W-1:0]     req_index,
   input  wire logic [sas_pkg::ELEM_W-1:0]    req_value,
   input  wire logic                          csr_we,
   input  wire logic                          csr_key_signed,
   input  wire sas_pkg::ctrl_cmd_type         cmd,
   output sas_pkg::dp_stat_type               stat,
   output logic [sas_pkg::STAT_W-1:0]         rsp_status,
   output logic [sas_pkg::ELEM_W-1:0]         rsp_data,
   output logic [sas_pkg::CNT_W-1:0]          rsp_position,
   output logic [sas_pkg::CNT_W-1:0]          rsp_count
);

   logic [sas_pkg::ELEM_W-1:0] entries_mem [sas_pkg::DEPTH];

   logic                        key_signed_ff, key_signed_in;
   logic [sas_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   sas_pkg::action_type         act_ff, act_in;
   logic [sas_pkg::IDX_W-1:0]   idx_ff, idx_in;
   logic [sas_pkg::ELEM_W-1:0]  key_ff, key_in;
   logic [sas_pkg::CNT_W-1:0]   first_ff, first_in;
   logic [sas_pkg::CNT_W-1:0]   len_ff, len_in;
   sas_pkg::status_type         res_status_ff, res_status_in;
   logic [sas_pkg::ELEM_W-1:0]  res_data_ff, res_data_in;
   logic [sas_pkg::CNT_W-1:0]   res_pos_ff, res_pos_in;
   logic [sas_pkg::ELEM_W-1:0]  rdata_ff;
   sas_pkg::status_type         out_status_ff;
   logic [sas_pkg::ELEM_W-1:0]  out_data_ff;
   logic [sas_pkg::CNT_W-1:0]   out_pos_ff, out_count_ff;

   logic                        rd_en, wr_en;
   logic [sas_pkg::IDX_W-1:0]   rd_addr, wr_addr;
   logic [sas_pkg::ELEM_W-1:0]  wr_data;
   logic [sas_pkg::CNT_W-1:0]   half, mid, last;
   logic                        go_right;

   assign half = len_ff >> 1;
   assign mid  = first_ff + half;
   assign last = cnt_ff - sas_pkg::CNT_W'(1);

   always_comb begin
      if (act_ff == sas_pkg::ACT_UPPER) begin
         go_right = !sas_pkg::less_than(key_ff, rdata_ff, key_signed_ff);
      end else begin
         go_right = sas_pkg::less_than(rdata_ff, key_ff, key_signed_ff);
      end
   end

   always_comb begin
      key_signed_in = csr_we ? csr_key_signed : key_signed_ff;
      cnt_in        = cnt_ff;
      act_in        = act_ff;
      idx_in        = idx_ff;
      key_in        = key_ff;
      first_in      = first_ff;
      len_in        = len_ff;
      res_status_in = res_status_ff;
      res_data_in   = res_data_ff;
      res_pos_in    = res_pos_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      case (cmd.op)
         sas_pkg::OP_LOAD: begin
            act_in        = sas_pkg::action_type'(req_action);
            idx_in        = req_index;
            key_in        = req_value;
            res_status_in = sas_pkg::STAT_OK;
            res_data_in   = '0;
            res_pos_in    = '0;
         end
         sas_pkg::OP_PUSH: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff[sas_pkg::IDX_W-1:0];
            wr_data = key_ff;
            cnt_in  = cnt_ff + sas_pkg::CNT_W'(1);
         end
         sas_pkg::OP_FULL: res_status_in = sas_pkg::STAT_FULL;
         sas_pkg::OP_FAIL: res_status_in = sas_pkg::STAT_ERR;
         sas_pkg::OP_RD_LAST: begin
            rd_en   = 1'b1;
            rd_addr = last[sas_pkg::IDX_W-1:0];
         end
         sas_pkg::OP_RD_INDEX: begin
            rd_en   = 1'b1;
            rd_addr = idx_ff;
         end
         sas_pkg::OP_TAKE: begin
            res_data_in = rdata_ff;
            if (act_ff inside {sas_pkg::ACT_POP, sas_pkg::ACT_SWAP}) begin
               cnt_in = last;
            end
            // last entry fills the hole; rewriting the last slot itself is harmless
            if (act_ff == sas_pkg::ACT_SWAP) begin
               wr_en   = 1'b1;
               wr_addr = idx_ff;
               wr_data = rdata_ff;
            end
         end
         sas_pkg::OP_SRCH_INIT: begin
            first_in = '0;
            len_in   = cnt_ff;
         end
         sas_pkg::OP_RD_MID: begin
            rd_en   = 1'b1;
            rd_addr = mid[sas_pkg::IDX_W-1:0];
         end
         sas_pkg::OP_STEP: begin
            if (go_right) begin
               first_in = mid + sas_pkg::CNT_W'(1);
               len_in   = len_ff - half - sas_pkg::CNT_W'(1);
            end else begin
               len_in = half;
            end
         end
         sas_pkg::OP_RD_FIRST: begin
            rd_en   = 1'b1;
            rd_addr = first_ff[sas_pkg::IDX_W-1:0];
         end
         sas_pkg::OP_POS_FIRST: res_pos_in = first_ff;
         sas_pkg::OP_POS_CHECK: res_pos_in = (rdata_ff == key_ff) ? first_ff : cnt_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_signed_ff <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         key_signed_ff <= key_signed_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      idx_ff        <= idx_in;
      key_ff        <= key_in;
      first_ff      <= first_in;
      len_ff        <= len_in;
      res_status_ff <= res_status_in;
      res_data_ff   <= res_data_in;
      res_pos_ff    <= res_pos_in;
      if (cmd.out_load) begin
         out_status_ff <= res_status_ff;
         out_data_ff   <= res_data_ff;
         out_pos_ff    <= res_pos_ff;
         out_count_ff  <= cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= entries_mem[rd_addr];
      end
   end

   assign stat.act         = act_ff;
   assign stat.empty       = (cnt_ff == '0);
   assign stat.full        = (cnt_ff == sas_pkg::CNT_W'(sas_pkg::DEPTH));
   assign stat.idx_oob     = ({1'b0, idx_ff} >= cnt_ff);
   assign stat.len_zero    = (len_ff == '0);
   assign stat.first_valid = (first_ff < cnt_ff);

   assign rsp_status   = out_status_ff;
   assign rsp_data     = out_data_ff;
   assign rsp_position = out_pos_ff;
   assign rsp_count    = out_count_ff;

endmodule

`default_nettype wire

### rtl/core/sas_ctrl.sv
// controller: sequences one item through the datapath and owns the result handshake
`default_nettype none

module sas_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire sas_pkg::dp_stat_type  stat,
   output sas_pkg::ctrl_cmd_type      cmd
);

   sas_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;
   logic               is_exact;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign is_exact = (stat.act == sas_pkg::ACT_EXACT);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sas_pkg::ST_IDLE: if (req_valid) state_in = sas_pkg::ST_EXEC;
         sas_pkg::ST_EXEC: begin
            case (stat.act)
               sas_pkg::ACT_PUSH: state_in = sas_pkg::ST_DONE;
               sas_pkg::ACT_POP:
                  state_in = stat.empty ? sas_pkg::ST_DONE : sas_pkg::ST_MEM;
               sas_pkg::ACT_READ, sas_pkg::ACT_SWAP:
                  state_in = stat.idx_oob ? sas_pkg::ST_DONE : sas_pkg::ST_MEM;
               sas_pkg::ACT_LOWER, sas_pkg::ACT_UPPER, sas_pkg::ACT_EXACT:
                  state_in = sas_pkg::ST_PROBE;
               default: state_in = sas_pkg::ST_DONE;
            endcase
         end
         sas_pkg::ST_MEM: state_in = sas_pkg::ST_DONE;
         sas_pkg::ST_PROBE: begin
            if (!stat.len_zero) begin
               state_in = sas_pkg::ST_STEP;
            end else if (is_exact && stat.first_valid) begin
               state_in = sas_pkg::ST_CHECK;
            end else begin
               state_in = sas_pkg::ST_DONE;
            end
         end
         sas_pkg::ST_STEP:  state_in = sas_pkg::ST_PROBE;
         sas_pkg::ST_CHECK: state_in = sas_pkg::ST_DONE;
         sas_pkg::ST_DONE:  if (out_free) state_in = sas_pkg::ST_IDLE;
         default: state_in = sas_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready    = 1'b0;
      cmd.op       = sas_pkg::OP_IDLE;
      cmd.out_load = 1'b0;
      case (state_ff)
         sas_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = sas_pkg::OP_LOAD;
         end
         sas_pkg::ST_EXEC: begin
            case (stat.act)
               sas_pkg::ACT_PUSH:
                  cmd.op = stat.full ? sas_pkg::OP_FULL : sas_pkg::OP_PUSH;
               sas_pkg::ACT_POP:
                  cmd.op = stat.empty ? sas_pkg::OP_FAIL : sas_pkg::OP_RD_LAST;
               sas_pkg::ACT_READ:
                  cmd.op = stat.idx_oob ? sas_pkg::OP_FAIL : sas_pkg::OP_RD_INDEX;
               sas_pkg::ACT_SWAP:
                  cmd.op = stat.idx_oob ? sas_pkg::OP_FAIL : sas_pkg::OP_RD_LAST;
               sas_pkg::ACT_LOWER, sas_pkg::ACT_UPPER, sas_pkg::ACT_EXACT:
                  cmd.op = sas_pkg::OP_SRCH_INIT;
               default: cmd.op = sas_pkg::OP_FAIL;
            endcase
         end
         sas_pkg::ST_MEM: cmd.op = sas_pkg::OP_TAKE;
         sas_pkg::ST_PROBE: begin
            if (!stat.len_zero) begin
               cmd.op = sas_pkg::OP_RD_MID;
            end else if (is_exact && stat.first_valid) begin
               cmd.op = sas_pkg::OP_RD_FIRST;
            end else begin
               cmd.op = sas_pkg::OP_POS_FIRST;
            end
         end
         sas_pkg::ST_STEP:  cmd.op = sas_pkg::OP_STEP;
         sas_pkg::ST_CHECK: cmd.op = sas_pkg::OP_POS_CHECK;
         sas_pkg::ST_DONE:  cmd.out_load = out_free;
         default: ;
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sas_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire
